FILE: src/breakpoint_table_stepover_core_defines.svh
// Assertion macros for the breakpoint table RTL.
`ifndef BREAKPOINT_TABLE_STEPOVER_CORE_DEFINES_SVH
`define BREAKPOINT_TABLE_STEPOVER_CORE_DEFINES_SVH

// Checked on every rising edge of aclk outside of reset.
`define BTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define BTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: src/bts_pkg.sv
package bts_pkg;

    localparam int BREAKPOINT_SLOTS = 8;
    localparam int IDX_W = (BREAKPOINT_SLOTS > 1) ? $clog2(BREAKPOINT_SLOTS) : 1;

    localparam logic ACT_TOGGLE = 1'b0;
    localparam logic ACT_FETCH  = 1'b1;

    localparam logic [1:0] ST_ADDED   = 2'd0;
    localparam logic [1:0] ST_REMOVED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [7:0] PFX_CB = 8'hCB;
    localparam logic [7:0] PFX_DD = 8'hDD;
    localparam logic [7:0] PFX_ED = 8'hED;
    localparam logic [7:0] PFX_FD = 8'hFD;
    localparam logic [7:0] OP_CALL      = 8'hCD;
    localparam logic [7:0] OP_CLASS_MSK = 8'hC7;
    localparam logic [7:0] OP_CALL_CC   = 8'hC4;
    localparam logic [7:0] OP_RST       = 8'hC7;
    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_CALL = 2'd3;
    localparam logic [1:0] LEN_RST  = 2'd1;

    typedef struct packed {
        logic        action;
        logic [15:0] address;
        logic [7:0]  opcode;
    } in_t;

    typedef struct packed {
        logic        hit;
        logic        is_subroutine;
        logic [15:0] return_address;
        logic [1:0]  toggle_status;
    } out_t;

    // Microprogram step numbers.
    typedef logic [1:0] step_t;
    localparam step_t STEP_WAIT    = 2'd0;
    localparam step_t STEP_SCAN    = 2'd1;
    localparam step_t STEP_RESOLVE = 2'd2;

    typedef enum logic [1:0] {
        COND_ACCEPT    = 2'd0,
        COND_SCAN_DONE = 2'd1,
        COND_OUT_FREE  = 2'd2
    } cond_t;

    // One control word of the microprogram.
    typedef struct packed {
        logic  take_in;
        logic  scan;
        logic  resolve;
        cond_t cond;
        step_t tgt_true;
        step_t tgt_false;
    } ctrl_t;

    // Datapath flags that the sequencer branches on.
    typedef struct packed {
        logic accept;
        logic scan_done;
        logic out_free;
    } stat_t;

    function automatic ctrl_t rom_word(step_t step);
        ctrl_t w;
        w = '{take_in: 1'b0, scan: 1'b0, resolve: 1'b0, cond: COND_ACCEPT,
              tgt_true: STEP_WAIT, tgt_false: STEP_WAIT};
        case (step)
            STEP_WAIT: begin
                w.take_in   = 1'b1;
                w.cond      = COND_ACCEPT;
                w.tgt_true  = STEP_SCAN;
                w.tgt_false = STEP_WAIT;
            end
            STEP_SCAN: begin
                w.scan      = 1'b1;
                w.cond      = COND_SCAN_DONE;
                w.tgt_true  = STEP_RESOLVE;
                w.tgt_false = STEP_SCAN;
            end
            STEP_RESOLVE: begin
                w.resolve   = 1'b1;
                w.cond      = COND_OUT_FREE;
                w.tgt_true  = STEP_WAIT;
                w.tgt_false = STEP_RESOLVE;
            end
            default: begin
                w.cond      = COND_ACCEPT;
            end
        endcase
        return w;
    endfunction

    function automatic logic is_prefix(logic [7:0] b);
        return (b == PFX_CB) || (b == PFX_DD) || (b == PFX_ED) || (b == PFX_FD);
    endfunction

    function automatic logic [1:0] sub_len(logic [7:0] op);
        logic [1:0] len;
        len = LEN_NONE;
        if ((op == OP_CALL) || ((op & OP_CLASS_MSK) == OP_CALL_CC)) begin
            len = LEN_CALL;
        end else if ((op & OP_CLASS_MSK) == OP_RST) begin
            len = LEN_RST;
        end
        return len;
    endfunction

endpackage

FILE: src/bts_ram.sv
module bts_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/bts_useq.sv
module bts_useq (
    input  logic           aclk,
    input  logic           aresetn,
    input  bts_pkg::stat_t stat,
    output bts_pkg::ctrl_t ctrl
);

    bts_pkg::step_t pc_reg;
    bts_pkg::step_t pc_next;
    logic           cond_true;

    assign ctrl = bts_pkg::rom_word(pc_reg);

    always_comb begin
        case (ctrl.cond)
            bts_pkg::COND_ACCEPT:    cond_true = stat.accept;
            bts_pkg::COND_SCAN_DONE: cond_true = stat.scan_done;
            bts_pkg::COND_OUT_FREE:  cond_true = stat.out_free;
            default:                 cond_true = 1'b1;
        endcase
        pc_next = cond_true ? ctrl.tgt_true : ctrl.tgt_false;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= bts_pkg::STEP_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: src/bts_dpath.sv
`include "breakpoint_table_stepover_core_defines.svh"

module bts_dpath (
    input  logic           aclk,
    input  logic           aresetn,
    input  bts_pkg::ctrl_t ctrl,
    output bts_pkg::stat_t stat,
    input  logic           s_valid,
    input  bts_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output bts_pkg::out_t  m_data
);

    localparam int IW = bts_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(bts_pkg::BREAKPOINT_SLOTS - 1);

    bts_pkg::in_t  item_reg;
    logic          merged_reg, merged_next;
    logic [7:0]    prev_op_reg, prev_op_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          match_reg, match_next;
    logic [IW-1:0] match_idx_reg, match_idx_next;
    logic          free_reg, free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [bts_pkg::BREAKPOINT_SLOTS-1:0] valid_reg, valid_next;
    logic          out_valid_reg, out_valid_next;
    bts_pkg::out_t out_reg, out_next;

    logic          accept;
    logic          out_free;
    logic [15:0]   rdata;
    logic          slot_match;
    logic          ram_we;
    logic [1:0]    len;

    assign accept     = ctrl.take_in && s_valid;
    assign out_free   = !out_valid_reg || m_ready;
    assign slot_match = valid_reg[idx_reg] && (rdata == item_reg.address);
    assign len        = bts_pkg::sub_len(item_reg.opcode);

    assign stat.accept    = accept;
    assign stat.out_free  = out_free;
    assign stat.scan_done = merged_reg || slot_match || (idx_reg == LAST_IDX);

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // A new breakpoint is written only when a toggle resolves with no match.
    assign ram_we = ctrl.resolve && out_free && (item_reg.action == bts_pkg::ACT_TOGGLE)
                    && !match_reg && free_reg;

    bts_ram #(
        .WIDTH(16),
        .DEPTH(bts_pkg::BREAKPOINT_SLOTS)
    ) u_addr_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(free_idx_reg),
        .wdata(item_reg.address),
        .raddr(idx_next),
        .rdata(rdata)
    );

    always_comb begin
        merged_next    = merged_reg;
        prev_op_next   = prev_op_reg;
        idx_next       = idx_reg;
        match_next     = match_reg;
        match_idx_next = match_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;

        if (ctrl.take_in) begin
            idx_next   = '0;
            match_next = 1'b0;
            free_next  = 1'b0;
            if (accept) begin
                merged_next = 1'b0;
                if (s_data.action == bts_pkg::ACT_FETCH) begin
                    merged_next  = bts_pkg::is_prefix(prev_op_reg);
                    prev_op_next = s_data.opcode;
                end
            end
        end

        if (ctrl.scan) begin
            if (slot_match) begin
                match_next     = 1'b1;
                match_idx_next = idx_reg;
            end
            if (!valid_reg[idx_reg] && !free_reg) begin
                free_next     = 1'b1;
                free_idx_next = idx_reg;
            end
            if (!stat.scan_done) begin
                idx_next = idx_reg + IW'(1);
            end
        end

        if (ctrl.resolve && out_free) begin
            out_valid_next = 1'b1;
            out_next       = '0;
            if (item_reg.action == bts_pkg::ACT_TOGGLE) begin
                if (match_reg) begin
                    valid_next[match_idx_reg] = 1'b0;
                    out_next.toggle_status    = bts_pkg::ST_REMOVED;
                end else if (free_reg) begin
                    valid_next[free_idx_reg] = 1'b1;
                    out_next.toggle_status   = bts_pkg::ST_ADDED;
                end else begin
                    out_next.toggle_status = bts_pkg::ST_FULL;
                end
            end else if (!merged_reg) begin
                out_next.hit = match_reg;
                if (len != bts_pkg::LEN_NONE) begin
                    out_next.is_subroutine  = 1'b1;
                    out_next.return_address = item_reg.address + {14'd0, len};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_op_reg   <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            merged_reg    <= 1'b0;
            idx_reg       <= '0;
            match_reg     <= 1'b0;
            free_reg      <= 1'b0;
        end else begin
            prev_op_reg   <= prev_op_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            merged_reg    <= merged_next;
            idx_reg       <= idx_next;
            match_reg     <= match_next;
            free_reg      <= free_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        out_reg       <= out_next;
    end

    `BTS_ASSERT(a_accept_then_scan, accept |=> ctrl.scan, "accepted item did not start a scan")
    `BTS_ASSERT(a_out_from_resolve, $rose(out_valid_reg) |-> $past(ctrl.resolve), "result without resolve")
    `BTS_ASSERT(a_add_sets_valid, ram_we |=> valid_reg[$past(free_idx_reg)], "added slot not valid")

endmodule

FILE: src/breakpoint_table_stepover_core.sv
// Breakpoint comparator with step-over support for an 8-bit CPU bus monitor.
// Each input transfer is either a toggle (action 0), which removes the address
// from the breakpoint table if present, or else stores it in the lowest free
// slot and reports a full table when none is left, or an opcode fetch (action
// 1). A fetch that directly follows a CB, DD, ED or FD prefix byte is merged
// into the current instruction and reports all zeros; a boundary fetch reports
// a breakpoint hit and, for CALL or RST opcodes, the step-over return address.
// Every input transfer yields exactly one result transfer. One item is handled
// at a time, passing through the microprogram steps in turn: a wait step
// takes the item, a scan step compares one table slot per cycle until the
// first match or the last slot (a merged fetch ends the scan at once), and a
// resolve step updates the table and loads the result register. The resolve
// step is held for as long as the previous result still waits in the output
// register, so a stalled result receiver delays it. The slot scan is paced by
// the single read port of the address RAM. There is no clearing pass: of the
// table, only the per-slot valid bits are cleared by reset.
module breakpoint_table_stepover_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bts_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output bts_pkg::out_t m_data
);

    // Control word of the current microprogram step, and the flags it branches on.
    bts_pkg::ctrl_t ctrl;
    bts_pkg::stat_t stat;

    // The block takes a new transfer only in the wait step of the program. A
    // result still held in the output register does not block it; the
    // resolve step waits instead until that register is free.
    assign s_ready = ctrl.take_in;

    bts_useq u_useq (
        .aclk   (aclk),
        .aresetn(aresetn),
        .stat   (stat),
        .ctrl   (ctrl)
    );

    bts_dpath u_dpath (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl   (ctrl),
        .stat   (stat),
        .s_valid(s_valid),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

endmodule

FILE: verif/breakpoint_table_stepover_core_checker.sv
module breakpoint_table_stepover_core_checker
    import bts_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  in_t  s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  out_t m_data,
    output int   error_count,
    output int   outstanding,
    output int   hit_count,
    output int   merged_count,
    output int   full_count
);

    // Shadow copy of the breakpoint table and the prefix tracker.
    logic [15:0] slot_addr [BREAKPOINT_SLOTS];
    logic        slot_used [BREAKPOINT_SLOTS];
    logic [7:0]  last_fetch_op;

    out_t monitor_results [$];
    int   mismatches;
    int   results_seen;
    int   hits;
    int   merged;
    int   dropped;

    initial begin
        for (int i = 0; i < BREAKPOINT_SLOTS; i++) begin
            slot_addr[i] = '0;
            slot_used[i] = 1'b0;
        end
        last_fetch_op = '0;
        mismatches    = 0;
        results_seen  = 0;
        hits          = 0;
        merged        = 0;
        dropped       = 0;
        error_count   = 0;
        outstanding   = 0;
        hit_count     = 0;
        merged_count  = 0;
        full_count    = 0;
    end

    // Works out the result of one bus event and advances the shadow state.
    function automatic out_t predict_monitor_result(in_t item);
        out_t res;
        logic found;
        logic after_prefix;
        int   i;
        res   = '0;
        found = 1'b0;
        if (item.action == ACT_TOGGLE) begin
            for (i = 0; i < BREAKPOINT_SLOTS; i++) begin
                if (!found && slot_used[i] && slot_addr[i] == item.address) begin
                    slot_used[i] = 1'b0;
                    found = 1'b1;
                end
            end
            if (found) begin
                res.toggle_status = ST_REMOVED;
            end else begin
                for (i = 0; i < BREAKPOINT_SLOTS; i++) begin
                    if (!found && !slot_used[i]) begin
                        slot_addr[i] = item.address;
                        slot_used[i] = 1'b1;
                        found = 1'b1;
                    end
                end
                res.toggle_status = found ? ST_ADDED : ST_FULL;
                if (!found) begin
                    dropped++;
                end
            end
        end else begin
            after_prefix = (last_fetch_op == PFX_CB) || (last_fetch_op == PFX_DD) ||
                           (last_fetch_op == PFX_ED) || (last_fetch_op == PFX_FD);
            last_fetch_op = item.opcode;
            if (after_prefix) begin
                merged++;
            end else begin
                for (i = 0; i < BREAKPOINT_SLOTS; i++) begin
                    if (slot_used[i] && slot_addr[i] == item.address) begin
                        res.hit = 1'b1;
                    end
                end
                if (res.hit) begin
                    hits++;
                end
                if (item.opcode == OP_CALL ||
                    (item.opcode & OP_CLASS_MSK) == OP_CALL_CC) begin
                    res.is_subroutine  = 1'b1;
                    res.return_address = item.address + LEN_CALL;
                end else if ((item.opcode & OP_CLASS_MSK) == OP_RST) begin
                    res.is_subroutine  = 1'b1;
                    res.return_address = item.address + LEN_RST;
                end
            end
        end
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch on result %0d: expected 0x%0h, got 0x%0h",
                     $time, field, results_seen, want, got);
        end
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                monitor_results.push_back(predict_monitor_result(s_data));
            end
            if (m_valid && m_ready) begin
                if (monitor_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result transfer: expected none, got 0x%0h",
                             $time, m_data);
                end else begin
                    want = monitor_results.pop_front();
                    compare_field("hit", want.hit, m_data.hit);
                    compare_field("is_subroutine", want.is_subroutine,
                                  m_data.is_subroutine);
                    compare_field("return_address", want.return_address,
                                  m_data.return_address);
                    compare_field("toggle_status", want.toggle_status,
                                  m_data.toggle_status);
                end
                results_seen++;
            end
        end
        error_count  <= mismatches;
        outstanding  <= monitor_results.size();
        hit_count    <= hits;
        merged_count <= merged;
        full_count   <= dropped;
    end

endmodule

FILE: verif/breakpoint_table_stepover_core_tb.sv
module breakpoint_table_stepover_core_tb;

    import bts_pkg::*;

    // Opcodes used by the directed part, in addition to the package codes.
    localparam logic [7:0] OP_NOP    = 8'h00;
    localparam logic [7:0] OP_HALT   = 8'h76;
    localparam logic [7:0] OP_CALL_M = 8'hFC;
    localparam logic [7:0] OP_RST_38 = 8'hFF;

    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS   = 650;
    localparam int POOL_SIZE      = 12;

    // Patterns the result receiver cycles through.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE,
        RX_ALTERNATE
    } rx_mode_e;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    int error_count;
    int outstanding;
    int hit_count;
    int merged_count;
    int full_count;

    int items_sent;
    int toggles_sent;
    int fetches_sent;
    int burst_left;

    in_t         directed [DIRECTED_ITEMS];
    logic [15:0] addr_pool [POOL_SIZE];

    always #2 aclk = ~aclk;

    breakpoint_table_stepover_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    breakpoint_table_stepover_core_checker checker_inst (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .error_count  (error_count),
        .outstanding  (outstanding),
        .hit_count    (hit_count),
        .merged_count (merged_count),
        .full_count   (full_count)
    );

    // The result receiver switches between stall patterns at randomly drawn
    // intervals, so that back pressure lands on every phase of the block's scan,
    // including long stretches where it never stalls at all.
    rx_mode_e rx_mode     = RX_ALWAYS;
    int       rx_left     = 0;
    logic     rx_alt      = 1'b0;

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        rx_alt = ~rx_alt;
        case (rx_mode)
            RX_ALWAYS: begin
                m_ready <= 1'b1;
            end
            RX_HALF: begin
                m_ready <= $urandom_range(0, 1);
            end
            RX_SPARSE: begin
                m_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_ready <= rx_alt;
            end
        endcase
    end

    // Presents one item and holds it until the block takes the transfer. The
    // handshake is sampled right after the edge, before any register in the
    // block has updated, so s_ready here is the value the edge itself saw.
    task automatic send_item(input in_t item);
        s_data  <= item;
        s_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        items_sent++;
        if (item.action == ACT_TOGGLE) begin
            toggles_sent++;
        end else begin
            fetches_sent++;
        end
    endtask

    // The sender works in bursts. Between bursts valid drops for a random
    // number of cycles; a zero gap simply joins two bursts back to back.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Holds the sender off until every result in flight has come back. The
    // first edge is waited out before the count is read, since the checker
    // publishes its count through a register, behind the transfer it reflects.
    task automatic drain_results();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (outstanding != 0);
    endtask

    // Fetch opcodes lean toward the interesting classes: prefix bytes, every
    // CALL and CALL cc, every RST vector, and a share of arbitrary bytes.
    function automatic logic [7:0] pick_opcode();
        logic [7:0] op;
        case ($urandom_range(0, 9))
            0, 1: begin
                case ($urandom_range(0, 3))
                    0:       op = PFX_CB;
                    1:       op = PFX_DD;
                    2:       op = PFX_ED;
                    default: op = PFX_FD;
                endcase
            end
            2: begin
                op = OP_CALL;
            end
            3, 4: begin
                op = OP_CALL_CC | (8'($urandom_range(0, 7)) << 3);
            end
            5: begin
                op = OP_RST | (8'($urandom_range(0, 7)) << 3);
            end
            default: begin
                op = 8'($urandom);
            end
        endcase
        return op;
    endfunction

    // Addresses mostly come from a small pool so that toggles both add and
    // remove, the table fills up, and fetches land on stored breakpoints. The
    // rest are neighbors of pool entries or fully random values.
    function automatic logic [15:0] pick_address();
        logic [15:0] addr;
        int          sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (sel == 6) begin
            addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)] + 16'd1;
        end else begin
            addr = 16'($urandom);
        end
        return addr;
    endfunction

    initial begin
        in_t item;
        int  i;

        items_sent   = 0;
        toggles_sent = 0;
        fetches_sent = 0;
        burst_left   = 0;

        // Directed part. The table is filled to its last slot, overflowed,
        // and partly emptied; then fetches cover hits, every subroutine class,
        // return addresses that wrap past the top of the address space, and
        // prefix merging including a chain of prefixes and a toggle placed
        // between a prefix and the byte that follows it.
        directed[0]  = {ACT_FETCH,  16'h0000, OP_NOP};     // empty table, no hit
        directed[1]  = {ACT_TOGGLE, 16'h0000, 8'hA5};      // added to the first slot
        directed[2]  = {ACT_TOGGLE, 16'hFFFF, 8'h5A};
        directed[3]  = {ACT_TOGGLE, 16'h1234, OP_NOP};
        directed[4]  = {ACT_TOGGLE, 16'h8001, OP_NOP};
        directed[5]  = {ACT_TOGGLE, 16'h4000, OP_NOP};
        directed[6]  = {ACT_TOGGLE, 16'h00FF, OP_NOP};
        directed[7]  = {ACT_TOGGLE, 16'hFF00, OP_NOP};
        directed[8]  = {ACT_TOGGLE, 16'hA5A5, OP_NOP};     // last free slot
        directed[9]  = {ACT_TOGGLE, 16'h5A5A, OP_NOP};     // table full, dropped
        directed[10] = {ACT_TOGGLE, 16'h1234, OP_NOP};     // removed from the middle
        directed[11] = {ACT_TOGGLE, 16'h5A5A, OP_NOP};     // reuses the freed slot
        directed[12] = {ACT_FETCH,  16'hFFFF, OP_RST_38};  // hit, RST wraps to zero
        directed[13] = {ACT_FETCH,  16'hFFFE, OP_CALL};    // CALL wraps to one
        directed[14] = {ACT_FETCH,  16'h0000, OP_CALL_CC}; // hit, conditional CALL
        directed[15] = {ACT_FETCH,  16'h8001, PFX_DD};     // hit on a prefix byte
        directed[16] = {ACT_TOGGLE, 16'h0100, OP_NOP};     // full again, prefix kept
        directed[17] = {ACT_FETCH,  16'h8002, PFX_CB};     // merged, chain goes on
        directed[18] = {ACT_FETCH,  16'h8003, OP_CALL};    // merged CALL
        directed[19] = {ACT_FETCH,  16'h4000, OP_CALL_M};  // boundary again, hit
        directed[20] = {ACT_FETCH,  16'h00FF, PFX_ED};     // hit on the ED prefix
        directed[21] = {ACT_FETCH,  16'hA5A5, OP_RST};     // merged despite breakpoint
        directed[22] = {ACT_FETCH,  16'hFF00, PFX_FD};     // hit on the FD prefix
        directed[23] = {ACT_FETCH,  16'h1111, OP_NOP};     // merged
        directed[24] = {ACT_FETCH,  16'hFF00, OP_HALT};    // hit, no subroutine

        for (i = 0; i < 8; i++) begin
            addr_pool[i] = directed[i + 1].address;
        end
        for (i = 8; i < POOL_SIZE; i++) begin
            addr_pool[i] = 16'($urandom);
        end

        // Synchronous reset, held low from the start and then released.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < DIRECTED_ITEMS; i++) begin
            send_item(directed[i]);
            if (i != DIRECTED_ITEMS - 1) begin
                pace_sender();
            end
        end
        drain_results();

        // Random part. About two fifths of the items are toggles, which keeps
        // the table hovering around full. Now and then a pool entry is swapped
        // for a fresh address so the table content keeps moving. Halfway
        // through, the sender waits for the block to go completely quiet.
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 49) begin
                addr_pool[$urandom_range(0, POOL_SIZE - 1)] = 16'($urandom);
            end
            item.action  = ($urandom_range(0, 9) < 4) ? ACT_TOGGLE : ACT_FETCH;
            item.address = pick_address();
            item.opcode  = (item.action == ACT_FETCH) ? pick_opcode() : 8'($urandom);
            send_item(item);
            if (i == RANDOM_ITEMS / 2) begin
                drain_results();
            end else if (i != RANDOM_ITEMS - 1) begin
                pace_sender();
            end
        end
        s_valid <= 1'b0;

        // Wait for the last results, then keep watching for any stray result
        // transfer, and read the counters away from the edge.
        do begin
            @(posedge aclk);
        end while (outstanding != 0);
        repeat (20) @(posedge aclk);
        @(negedge aclk);

        $display("Covered %0d items: %0d toggles (%0d dropped on a full table), %0d fetches",
                 items_sent, toggles_sent, full_count, fetches_sent);
        $display("Fetches gave %0d breakpoint hits and %0d merged prefix continuations",
                 hit_count, merged_count);
        if (error_count == 0 && outstanding == 0) begin
            $display("[breakpoint_table_stepover_core] OK");
        end else begin
            $display("[breakpoint_table_stepover_core] ERROR");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest correct run, even with the receiver
    // stalled most of the time and the longest sender gaps on every item.
    initial begin
        #2000000;
        $display("[breakpoint_table_stepover_core] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/bts_pkg.sv
src/bts_ram.sv
src/bts_useq.sv
src/bts_dpath.sv
src/breakpoint_table_stepover_core.sv
verif/breakpoint_table_stepover_core_checker.sv
verif/breakpoint_table_stepover_core_tb.sv
